// ===== rtl/core/whf_pkg.sv =====
// Shared types and constants for the waveform hit finder.
// Used by whf_front, whf_queue, whf_back and waveform_hit_finder_unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package whf_pkg;

  // Longest waveform supported; sample indices are sized from it
  localparam int MaxWaveLen = 4096;
  localparam int IdxW       = $clog2(MaxWaveLen);
  localparam int LenW       = IdxW + 1;

  // Field widths
  localparam int SampleW = 16;
  localparam int ThrW    = 15;
  localparam int MinW    = 12;
  localparam int LimW    = 10;
  localparam int CntW    = 11;
  localparam int NumW    = 10;
  localparam int CfgW    = 15;
  localparam int CfgAddrW = 2;
  localparam int OutDataW = 48;

  // Configuration register indices
  localparam logic [CfgAddrW-1:0] RegThreshold  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegMinWidth   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegHitLimit   = 2'd2;
  localparam logic [CfgAddrW-1:0] RegWaveLength = 2'd3;

  // Register reset values
  localparam logic [ThrW-1:0] ThresholdRst  = 15'd25;
  localparam logic [MinW-1:0] MinWidthRst   = 12'd6;
  localparam logic [LimW-1:0] HitLimitRst   = 10'd990;
  localparam logic [LenW-1:0] WaveLengthRst = 13'd1250;

  // Result kinds
  localparam logic KindHit     = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef struct packed {
    logic            kind;
    logic [IdxW-1:0] begin_index;
    logic [IdxW-1:0] end_index;
    logic [NumW-1:0] hit_number;
    logic [CntW-1:0] hit_total;
    logic            last;
  } whf_result_t;

  // All results caused by one input transaction
  typedef struct packed {
    logic        two;
    whf_result_t r0;
    whf_result_t r1;
  } whf_bundle_t;

endpackage
`default_nettype wire

// ===== rtl/core/whf_front.sv =====
// Front end: configuration registers, per-waveform state and hit detection.
// Emits a bundle of results into the queue for each input transaction that yields a hit or ends the waveform.
// Depends on whf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module whf_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [whf_pkg::CfgAddrW-1:0]      cfg_addr,
  input  wire  [whf_pkg::CfgW-1:0]          cfg_wdata,
  input  wire                               accept,
  input  wire  signed [whf_pkg::SampleW-1:0] sample,
  input  wire                               first,
  output logic                              push,
  output whf_pkg::whf_bundle_t              bundle
);

  logic [whf_pkg::ThrW-1:0] threshold_r;
  logic [whf_pkg::MinW-1:0] min_width_r;
  logic [whf_pkg::LimW-1:0] hit_limit_r;
  logic [whf_pkg::LenW-1:0] wave_length_r;

  logic                     in_pulse_r, in_pulse_nxt;
  logic [whf_pkg::IdxW-1:0] index_r, index_nxt;
  logic [whf_pkg::IdxW-1:0] last_neg_r, last_neg_nxt;
  logic [whf_pkg::IdxW-1:0] open_begin_r, open_begin_nxt;
  logic [whf_pkg::CntW-1:0] hit_count_r, hit_count_nxt;
  logic                     stopped_r, stopped_nxt;
  logic                     done_r, done_nxt;

  // State as seen after an optional restart by a first mark
  logic                     pulse_cur, stop_cur, done_cur;
  logic [whf_pkg::IdxW-1:0] idx_cur, neg_cur, open_cur;
  logic [whf_pkg::CntW-1:0] cnt_cur;

  logic [whf_pkg::LenW-1:0] len_eff;
  logic [whf_pkg::LenW-1:0] len_m1;
  logic [whf_pkg::IdxW-1:0] width;
  logic                     hit, wave_end;
  whf_pkg::whf_result_t     hit_res, sum_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= whf_pkg::ThresholdRst;
      min_width_r   <= whf_pkg::MinWidthRst;
      hit_limit_r   <= whf_pkg::HitLimitRst;
      wave_length_r <= whf_pkg::WaveLengthRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        whf_pkg::RegThreshold:  threshold_r   <= cfg_wdata[whf_pkg::ThrW-1:0];
        whf_pkg::RegMinWidth:   min_width_r   <= cfg_wdata[whf_pkg::MinW-1:0];
        whf_pkg::RegHitLimit:   hit_limit_r   <= cfg_wdata[whf_pkg::LimW-1:0];
        whf_pkg::RegWaveLength: wave_length_r <= cfg_wdata[whf_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length to 1 .. MaxWaveLen
  always_comb begin
    if (wave_length_r == '0) begin
      len_eff = whf_pkg::LenW'(1);
    end else if (wave_length_r > whf_pkg::LenW'(whf_pkg::MaxWaveLen)) begin
      len_eff = whf_pkg::LenW'(whf_pkg::MaxWaveLen);
    end else begin
      len_eff = wave_length_r;
    end
    len_m1 = len_eff - whf_pkg::LenW'(1);
  end

  // Restart view
  assign pulse_cur = first ? 1'b0 : in_pulse_r;
  assign stop_cur  = first ? 1'b0 : stopped_r;
  assign done_cur  = first ? 1'b0 : done_r;
  assign idx_cur   = first ? '0 : index_r;
  assign neg_cur   = first ? '0 : last_neg_r;
  assign open_cur  = first ? '0 : open_begin_r;
  assign cnt_cur   = first ? '0 : hit_count_r;
  assign width     = idx_cur - open_cur;

  // Per-sample update
  always_comb begin
    in_pulse_nxt   = in_pulse_r;
    index_nxt      = index_r;
    last_neg_nxt   = last_neg_r;
    open_begin_nxt = open_begin_r;
    hit_count_nxt  = hit_count_r;
    stopped_nxt    = stopped_r;
    done_nxt       = done_r;
    hit            = 1'b0;
    wave_end       = 1'b0;
    if (accept) begin
      in_pulse_nxt   = pulse_cur;
      index_nxt      = idx_cur;
      last_neg_nxt   = neg_cur;
      open_begin_nxt = open_cur;
      hit_count_nxt  = cnt_cur;
      stopped_nxt    = stop_cur;
      done_nxt       = done_cur;
      if (!done_cur) begin
        if ({1'b0, idx_cur} >= len_eff) begin
          // past the length: ignore until the next first mark
          done_nxt = 1'b1;
        end else begin
          if (!stop_cur) begin
            if (!pulse_cur) begin
              if (sample > $signed({1'b0, threshold_r})) begin
                in_pulse_nxt   = 1'b1;
                open_begin_nxt = neg_cur;
              end
            end else if (sample <= $signed(whf_pkg::SampleW'(0))) begin
              in_pulse_nxt = 1'b0;
              if (width > min_width_r) begin
                hit           = 1'b1;
                hit_count_nxt = cnt_cur + whf_pkg::CntW'(1);
              end
              if (hit_count_nxt > {1'b0, hit_limit_r}) begin
                stopped_nxt = 1'b1;
              end
            end
            if (sample < $signed(whf_pkg::SampleW'(0)) && idx_cur != '0) begin
              last_neg_nxt = idx_cur;
            end
          end
          if ({1'b0, idx_cur} == len_m1) begin
            wave_end     = 1'b1;
            in_pulse_nxt = 1'b0;
            done_nxt     = 1'b1;
          end else begin
            index_nxt = idx_cur + whf_pkg::IdxW'(1);
          end
        end
      end
    end
  end

  // Result formation
  always_comb begin
    hit_res.kind        = whf_pkg::KindHit;
    hit_res.begin_index = open_cur;
    hit_res.end_index   = idx_cur;
    hit_res.hit_number  = cnt_cur[whf_pkg::NumW-1:0];
    hit_res.hit_total   = hit_count_nxt;
    hit_res.last        = !wave_end;

    sum_res.kind        = whf_pkg::KindSummary;
    sum_res.begin_index = '0;
    sum_res.end_index   = '0;
    sum_res.hit_number  = '0;
    sum_res.hit_total   = hit_count_nxt;
    sum_res.last        = 1'b1;

    bundle.two = hit && wave_end;
    bundle.r0  = hit ? hit_res : sum_res;
    bundle.r1  = sum_res;
    push       = hit || wave_end;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pulse_r   <= 1'b0;
      index_r      <= '0;
      last_neg_r   <= '0;
      open_begin_r <= '0;
      hit_count_r  <= '0;
      stopped_r    <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      in_pulse_r   <= in_pulse_nxt;
      index_r      <= index_nxt;
      last_neg_r   <= last_neg_nxt;
      open_begin_r <= open_begin_nxt;
      hit_count_r  <= hit_count_nxt;
      stopped_r    <= stopped_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/whf_queue.sv =====
// Short FIFO of result bundles between front and back.
// Depends on whf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module whf_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  whf_pkg::whf_bundle_t  wr_data,
  input  wire                   pop,
  output whf_pkg::whf_bundle_t  rd_data,
  output logic                  not_empty,
  output logic                  full
);

  whf_pkg::whf_bundle_t      mem [whf_pkg::QueueDepth];
  logic [whf_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [whf_pkg::QPtrW:0]   count_r, count_nxt;

  assign not_empty = count_r != '0;
  assign full      = count_r == (whf_pkg::QPtrW+1)'(whf_pkg::QueueDepth);
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (whf_pkg::QPtrW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (whf_pkg::QPtrW+1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + whf_pkg::QPtrW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + whf_pkg::QPtrW'(1);
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/whf_back.sv =====
// Back end: unpacks bundles into single results and holds the output register.
// Depends on whf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module whf_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  whf_pkg::whf_bundle_t  q_data,
  input  wire                   q_not_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output whf_pkg::whf_result_t  out_res
);

  logic                 out_valid_r;
  whf_pkg::whf_result_t out_res_r;
  logic                 sec_valid_r;
  whf_pkg::whf_result_t sec_res_r;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = slot_free && !sec_valid_r && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Output register and held second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        out_valid_r <= q_not_empty;
        sec_valid_r <= q_not_empty && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (sec_valid_r) begin
        out_res_r <= sec_res_r;
      end else begin
        out_res_r <= q_data.r0;
        sec_res_r <= q_data.r1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/waveform_hit_finder_unit.sv =====
// Top level of the waveform hit finder: stream ports and configuration port.
// Depends on whf_pkg, whf_front, whf_queue and whf_back.
`timescale 1ns / 1ps
`default_nettype none
// Finds threshold-crossing hits in baseline-subtracted waveform samples and
// reports each kept hit (begin, end, ordinal, running total) and, after the
// last sample of a waveform, a summary with the hit total. The front takes one
// sample every clock while the four-entry result queue has room; a sample
// that yields a hit at the last index gives two results, which leave one
// after the other as the output takes them, so the output side sets the pace
// when it stalls or when hit and summary results bunch up. A result passes
// through the queue and the output register; no clearing pass runs after reset.
module waveform_hit_finder_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration
  input  wire                            cfg_we,
  input  wire  [whf_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire  [whf_pkg::CfgW-1:0]       cfg_wdata,
  // input samples
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [whf_pkg::SampleW-1:0]    in_tdata,   // [15:0] sample
  input  wire                            in_tuser,   // [0] first
  // results
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [whf_pkg::OutDataW-1:0]   out_tdata,  // begin_index, end_index,
                                                     // hit_number, hit_total, 0 pad
  output logic                           out_tuser,  // [0] kind
  output logic                           out_tlast
);

  logic                 accept;
  logic                 push;
  logic                 q_full, q_not_empty, q_pop;
  whf_pkg::whf_bundle_t wr_bundle, rd_bundle;
  whf_pkg::whf_result_t res;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  whf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .sample    ($signed(in_tdata)),
    .first     (in_tuser),
    .push      (push),
    .bundle    (wr_bundle)
  );

  whf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_bundle),
    .pop       (q_pop),
    .rd_data   (rd_bundle),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  whf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (rd_bundle),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  // Pack result fields, lowest first
  assign out_tdata = {3'b000, res.hit_total, res.hit_number, res.end_index, res.begin_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
`default_nettype wire
